@@ design/arpc_pkg.sv @@
package arpc_pkg;

	localparam int unsigned ENTRIES_DEF = 16;

	localparam logic [1:0] LIFE_EMPTY = 2'd0;
	localparam logic [1:0] LIFE_TEMP  = 2'd1;
	localparam logic [1:0] LIFE_PERM  = 2'd2;

	localparam logic [2:0] KIND_PKT     = 3'd0;
	localparam logic [2:0] KIND_LK_IP   = 3'd1;
	localparam logic [2:0] KIND_LK_MAC  = 3'd2;
	localparam logic [2:0] KIND_RM_IP   = 3'd3;
	localparam logic [2:0] KIND_RM_MAC  = 3'd4;

	localparam logic [2:0] ST_DROP    = 3'd0;
	localparam logic [2:0] ST_LEARN   = 3'd1;
	localparam logic [2:0] ST_REPLY   = 3'd2;
	localparam logic [2:0] ST_HIT     = 3'd3;
	localparam logic [2:0] ST_MISS    = 3'd4;
	localparam logic [2:0] ST_REMOVED = 3'd5;
	localparam logic [2:0] ST_NOTFND  = 3'd6;

	localparam logic [10:0] MIN_LEN     = 11'd28;
	localparam logic [15:0] HW_ETHERNET = 16'd1;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
	localparam logic [7:0]  PR_ADDR_LEN = 8'd4;
	localparam logic [15:0] OP_REQUEST  = 16'd1;

	localparam logic CFG_MY_MAC = 1'b0;
	localparam logic CFG_MY_IP  = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] frame_len;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
	} arpc_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] mac;
		logic [31:0] ip;
	} arpc_out_t;

	typedef struct packed {
		logic [1:0]  life;
		logic [15:0] proto;
		logic [47:0] mac;
		logic [31:0] ip;
	} arpc_entry_t;

endpackage

@@ design/arp_cache_responder.sv @@
// arp cache and responder: one word in gives one word out. each word walks the
// entry memory once, one entry a cycle (one read port, read data registered),
// and then writes at most one entry back; a dropped packet or an unknown kind
// walks the memory too. the result sits in an output register and the next
// word is accepted the cycle after it has been taken, so the block does not
// take a new word before the last result has been taken by the receiver.
// each entry word holds life, protocol, mac and ip; a valid flag per entry,
// cleared by reset, makes unwritten entries read as empty, so the table is
// empty at once and needs no clearing pass. my_mac is stored but not used in
// the result word.
module arp_cache_responder
	import arpc_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  arpc_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output arpc_out_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	logic [47:0] my_mac_q;
	logic [31:0] my_ip_q;
	arpc_in_t item_q;

	// entry memory (life, proto, mac, ip) plus a valid flag per entry
	arpc_entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	arpc_entry_t rd_s1;
	logic [AW-1:0] raddr_q, rd_idx_s1;
	logic rd_v_s1, rd_last_s1;

	// scan results
	logic hit_q, emp_q, tmp_q;
	logic [AW-1:0] hit_idx_q, emp_idx_q, tmp_idx_q;
	logic [1:0] hit_life_q;
	logic [47:0] hit_mac_q;
	logic [31:0] hit_ip_q;
	arpc_out_t res_q;
	arpc_out_t res_d;

	// memory write
	logic we;
	logic [AW-1:0] waddr;
	arpc_entry_t wdata;

	// current entry compare
	logic [15:0] e_proto;
	logic [47:0] e_mac;
	logic [31:0] e_ip;
	logic [1:0] e_life;
	logic by_mac, match, pkt_ok, to_me;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	assign by_mac = (item_q.kind == KIND_LK_MAC) || (item_q.kind == KIND_RM_MAC);
	assign e_proto = rd_s1.proto;
	assign e_mac = rd_s1.mac;
	assign e_ip = rd_s1.ip;
	assign e_life = rd_s1.life;
	assign match = (e_life != LIFE_EMPTY) && (e_proto == item_q.proto_type) &&
		(by_mac ? (e_mac == item_q.sender_mac) : (e_ip == item_q.sender_ip));
	assign pkt_ok = (item_q.frame_len >= MIN_LEN) && (item_q.hw_type == HW_ETHERNET) &&
		(item_q.proto_type == PROTO_IPV4) && (item_q.hw_len == HW_ADDR_LEN) &&
		(item_q.proto_len == PR_ADDR_LEN);
	assign to_me = (item_q.target_ip == my_ip_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_mac_q <= '0;
			my_ip_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MY_MAC: my_mac_q <= cfg_data;
				CFG_MY_IP:  my_ip_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// memory: synchronous read, one write port; fresh entries read as empty
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_s1 <= vld_q[raddr_q] ? mem[raddr_q] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// write-back decision
	always_comb begin
		we = 1'b0;
		waddr = hit_idx_q;
		wdata = '0;
		if (state_q == S_WRITE) begin
			case (item_q.kind)
				KIND_PKT: begin
					if (pkt_ok) begin
						we = 1'b1;
						if (hit_q) begin
							// known ip: mac only, longevity kept
							waddr = hit_idx_q;
							wdata = {hit_life_q, item_q.proto_type, item_q.sender_mac,
								hit_ip_q};
						end else begin
							waddr = emp_q ? emp_idx_q : (tmp_q ? tmp_idx_q : AW'(ENTRIES - 1));
							wdata = {(to_me ? LIFE_PERM : LIFE_TEMP), item_q.proto_type,
								item_q.sender_mac, item_q.sender_ip};
						end
					end
				end
				KIND_RM_IP, KIND_RM_MAC: begin
					if (hit_q) begin
						// removal keeps the stored protocol
						we = 1'b1;
						waddr = hit_idx_q;
						wdata = {LIFE_EMPTY, item_q.proto_type, 80'd0};
					end
				end
				default: ;
			endcase
		end
	end

	// result word built from the scan outcome
	always_comb begin
		res_d = '0;
		case (item_q.kind)
			KIND_PKT: begin
				if (pkt_ok) begin
					if (item_q.opcode == OP_REQUEST && to_me) begin
						res_d.status = ST_REPLY;
						res_d.mac = item_q.sender_mac;
						res_d.ip = item_q.sender_ip;
					end else begin
						res_d.status = ST_LEARN;
					end
				end
			end
			KIND_LK_IP: begin
				if (hit_q && item_q.proto_type != '0) begin
					res_d.status = ST_HIT;
					res_d.mac = hit_mac_q;
				end else begin
					res_d.status = ST_MISS;
				end
			end
			KIND_LK_MAC: begin
				if (hit_q) begin
					res_d.status = ST_HIT;
					res_d.ip = hit_ip_q;
				end else begin
					res_d.status = ST_MISS;
				end
			end
			KIND_RM_IP, KIND_RM_MAC: res_d.status = hit_q ? ST_REMOVED : ST_NOTFND;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			raddr_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						raddr_q <= '0;
						rd_v_s1 <= 1'b0;
						rd_last_s1 <= 1'b0;
					end
				end
				S_SCAN: begin
					rd_v_s1 <= !(rd_v_s1 && rd_last_s1);
					rd_idx_s1 <= raddr_q;
					rd_last_s1 <= (raddr_q == AW'(ENTRIES - 1));
					if (raddr_q != AW'(ENTRIES - 1))
						raddr_q <= raddr_q + 1'b1;
					if (rd_v_s1 && rd_last_s1)
						state_q <= S_WRITE;
				end
				S_WRITE: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture, scan bookkeeping and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= in_data;
				hit_q <= 1'b0;
				emp_q <= 1'b0;
				tmp_q <= 1'b0;
			end
			S_SCAN: begin
				if (rd_v_s1) begin
					if (match && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_life_q <= e_life;
						hit_mac_q <= e_mac;
						hit_ip_q <= e_ip;
					end
					if (e_life == LIFE_EMPTY && !emp_q) begin
						emp_q <= 1'b1;
						emp_idx_q <= rd_idx_s1;
					end
					if (e_life == LIFE_TEMP && !tmp_q) begin
						tmp_q <= 1'b1;
						tmp_idx_q <= rd_idx_s1;
					end
				end
			end
			S_WRITE: res_q <= res_d;
			default: ;
		endcase
	end

	logic unused_mac;
	assign unused_mac = ^my_mac_q;

endmodule
